@@ rtl/teq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timed event queue
// Entry layout, beat structs, command and status bundles and the codes that
// the controller and the datapath agree on.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned MAX_OUT = 16;
  localparam int unsigned OCC_W   = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

  // Request codes carried in the kind field of an input beat.
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_EXECUTE = 2'd1;
  localparam logic [1:0] KIND_REMOVE  = 2'd2;

  // Status codes carried in a result beat.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_FIRED    = 3'd2;
  localparam logic [2:0] ST_NONE_DUE = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] due_time;
    logic [15:0] event_arg;
    logic [3:0]  event_kind;
    logic [7:0]  handler_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [15:0] fired_arg;
    logic [3:0]  fired_kind;
    logic [7:0]  fired_handler;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] due;
    logic [15:0] arg;
    logic [3:0]  kind;
    logic [7:0]  handler;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_EXEC,
    S_REMOVE
  } state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INSERT,
    OP_FULL,
    OP_POP,
    OP_NONE_DUE,
    OP_REMOVE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/teq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_datapath: sorted entry chain, request register and result register
// Each cell compares itself with the held request and shifts in from its
// neighbour on insert, remove or pop. Results leave through a register.
// ----------------------------------------------------------------------------
module teq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  teq_pkg::cmd_t      cmd_i,
  output teq_pkg::stat_t     stat_o,
  input  teq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output teq_pkg::out_item_t out_item_o
);

  teq_pkg::in_item_t               item_q;
  teq_pkg::entry_t                 ent_q [teq_pkg::DEPTH];
  teq_pkg::entry_t                 new_w;
  logic [teq_pkg::OCC_W-1:0]       occ_q, occ_d;
  logic [teq_pkg::DEPTH-1:0]       le, match, hit;
  logic                            found;
  logic                            emit;
  logic                            out_valid_q, out_valid_d;
  teq_pkg::out_item_t              out_q, out_d;

  assign new_w = '{due: item_q.due_time, arg: item_q.event_arg,
                   kind: item_q.event_kind, handler: item_q.handler_id};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == teq_pkg::OP_LOAD) begin
      item_q <= in_item_i;
    end
  end

  // One cell per entry; valid entries form a prefix of length occ_q.
  for (genvar g = 0; g < teq_pkg::DEPTH; g++) begin : g_cell
    logic            valid_w;
    logic            prev_le;
    teq_pkg::entry_t prev_w, next_w, ent_d;

    assign valid_w  = (occ_q > teq_pkg::OCC_W'(g));
    assign le[g]    = valid_w && (ent_q[g].due <= item_q.due_time);
    assign match[g] = valid_w && (ent_q[g].arg == item_q.event_arg)
                      && (ent_q[g].kind == item_q.event_kind);

    if (g == 0) begin : g_head
      assign prev_w  = new_w;
      assign prev_le = 1'b1;
    end else begin : g_body
      assign prev_w  = ent_q[g-1];
      assign prev_le = le[g-1];
    end

    if (g == teq_pkg::DEPTH - 1) begin : g_tail
      assign next_w = ent_q[g];
    end else begin : g_inner
      assign next_w = ent_q[g+1];
    end

    always_comb begin
      ent_d = ent_q[g];
      unique case (cmd_i.op)
        teq_pkg::OP_INSERT: begin
          if (!le[g]) begin
            ent_d = prev_le ? new_w : prev_w;
          end
        end
        teq_pkg::OP_REMOVE: begin
          if (hit[g]) begin
            ent_d = next_w;
          end
        end
        teq_pkg::OP_POP: begin
          ent_d = next_w;
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      ent_q[g] <= ent_d;
    end
  end

  // Marks the first matching entry and every entry behind it.
  always_comb begin
    hit[0] = match[0];
    for (int i = 1; i < teq_pkg::DEPTH; i++) begin
      hit[i] = hit[i-1] | match[i];
    end
  end

  assign found = hit[teq_pkg::DEPTH-1];

  always_comb begin
    occ_d = occ_q;
    unique case (cmd_i.op)
      teq_pkg::OP_INSERT: occ_d = occ_q + teq_pkg::OCC_W'(1);
      teq_pkg::OP_POP:    occ_d = occ_q - teq_pkg::OCC_W'(1);
      teq_pkg::OP_REMOVE: occ_d = found ? occ_q - teq_pkg::OCC_W'(1) : occ_q;
      default:            occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign stat_o.full     = (occ_q == teq_pkg::OCC_W'(teq_pkg::DEPTH));
  assign stat_o.head_due = (occ_q != '0) && (ent_q[0].due == item_q.due_time);
  assign stat_o.next_due = (occ_q > teq_pkg::OCC_W'(1))
                           && (ent_q[1].due == item_q.due_time);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // Result register.
  always_comb begin
    emit  = 1'b1;
    out_d = '0;
    out_d.last = 1'b1;
    unique case (cmd_i.op)
      teq_pkg::OP_INSERT:   out_d.status = teq_pkg::ST_INSERTED;
      teq_pkg::OP_FULL:     out_d.status = teq_pkg::ST_FULL;
      teq_pkg::OP_NONE_DUE: out_d.status = teq_pkg::ST_NONE_DUE;
      teq_pkg::OP_REMOVE: begin
        out_d.status = teq_pkg::ST_REMOVED;
        out_d.found  = found;
      end
      teq_pkg::OP_POP: begin
        out_d.status        = teq_pkg::ST_FIRED;
        out_d.fired_arg     = ent_q[0].arg;
        out_d.fired_kind    = ent_q[0].kind;
        out_d.fired_handler = ent_q[0].handler;
        out_d.last          = cmd_i.last;
      end
      default: emit = 1'b0;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= teq_pkg::OCC_W'(teq_pkg::DEPTH))
    else $error("occupancy beyond depth");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == teq_pkg::OP_INSERT |=>
      occ_q == teq_pkg::OCC_W'($past(occ_q) + 1'b1))
    else $error("insert did not grow the queue");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("result written over a stalled beat");

endmodule

@@ rtl/teq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_ctrl: request sequencer of the timed event queue
// Takes one request, then issues insert or full, remove, or a run of pops or a
// nothing-due beat to the datapath whenever the result register can take a beat.
// ----------------------------------------------------------------------------
module teq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_kind_i,
  output logic           in_stall_o,
  input  teq_pkg::stat_t stat_i,
  output teq_pkg::cmd_t  cmd_o
);

  teq_pkg::state_e           state_q, state_d;
  logic [teq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      can_pop, pop_last;

  assign can_pop  = stat_i.head_due && (cnt_q < teq_pkg::CNT_W'(teq_pkg::MAX_OUT));
  assign pop_last = !(stat_i.next_due
                      && ((cnt_q + teq_pkg::CNT_W'(1))
                          < teq_pkg::CNT_W'(teq_pkg::MAX_OUT)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      teq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          priority if (in_kind_i == teq_pkg::KIND_INSERT)  state_d = teq_pkg::S_INSERT;
          else if (in_kind_i == teq_pkg::KIND_EXECUTE)     state_d = teq_pkg::S_EXEC;
          else if (in_kind_i == teq_pkg::KIND_REMOVE)      state_d = teq_pkg::S_REMOVE;
          else                                             state_d = teq_pkg::S_IDLE;
        end
      end
      teq_pkg::S_INSERT, teq_pkg::S_REMOVE: begin
        if (stat_i.out_free) begin
          state_d = teq_pkg::S_IDLE;
        end
      end
      teq_pkg::S_EXEC: begin
        if (stat_i.out_free && (!can_pop || pop_last)) begin
          state_d = teq_pkg::S_IDLE;
        end
      end
      default: state_d = teq_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o.op   = teq_pkg::OP_NOP;
    cmd_o.last = 1'b1;
    unique case (state_q)
      teq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = teq_pkg::OP_LOAD;
        end
      end
      teq_pkg::S_INSERT: begin
        if (stat_i.out_free) begin
          cmd_o.op = stat_i.full ? teq_pkg::OP_FULL : teq_pkg::OP_INSERT;
        end
      end
      teq_pkg::S_REMOVE: begin
        if (stat_i.out_free) begin
          cmd_o.op = teq_pkg::OP_REMOVE;
        end
      end
      teq_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          if (can_pop) begin
            cmd_o.op   = teq_pkg::OP_POP;
            cmd_o.last = pop_last;
          end else begin
            cmd_o.op = teq_pkg::OP_NONE_DUE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.op == teq_pkg::OP_LOAD) begin
      cnt_d = '0;
    end else if (cmd_o.op == teq_pkg::OP_POP) begin
      cnt_d = cnt_q + teq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= teq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_pop_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == teq_pkg::OP_POP |-> cnt_q < teq_pkg::CNT_W'(teq_pkg::MAX_OUT))
    else $error("more pops than one execute allows");

  a_none_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == teq_pkg::OP_NONE_DUE |-> cnt_q == '0)
    else $error("nothing-due beat after fired events");

endmodule

@@ rtl/timed_event_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue: event queue kept in order of due time
// Inserts, fires and removes events held in a chain of sorted cells.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Beat
//   --------+-----------+-------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o | teq_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | teq_pkg::out_item_t
//
// A request is taken while the sequencer is idle and answered once the result
// register is free; insert and remove give one result beat each, an execute
// gives one beat per fired event, or a single beat when nothing is due. All requests
// share the single cell chain. Reset clears the sequencer, the occupancy and
// the result valid;
// entry contents are not cleared, as only valid entries are ever read. A
// stall on the result side holds the sequencer in its working state, while a
// finished beat may wait in the result register as the next request arrives.
//
// Each cell compares its own due time with the request, so an insert needs no
// search: a cell whose time is later than the new one takes either the new
// event or its neighbour's. Remove deletes the first matching entry by shifting
// every entry behind it one place towards the head. Execute pops the head
// while its due time equals the given time, at most MAX_OUT times, and marks
// the final fired beat as last; with nothing due it returns a single beat.
// Unknown request codes are taken and dropped without a result.
// ----------------------------------------------------------------------------
module timed_event_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  teq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output teq_pkg::out_item_t out_item_o
);

  teq_pkg::cmd_t  cmd;
  teq_pkg::stat_t stat;

  teq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  teq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
